// File: rtl/core/utt_pkg.sv
// ----------------------------------------------------------------------------
// utt_pkg: shared types and constants of the UTF-8 to UTF-16 transcoder
// Holds the result group that passes from the decoder to the serializer, and
// the code unit constants that both stages use.
// ----------------------------------------------------------------------------
package utt_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned UnitWidth = 16;
   localparam int unsigned CpWidth   = 21;

   localparam logic [UnitWidth-1:0] REPLACEMENT_UNIT = 16'hFFFD;
   localparam logic [UnitWidth-1:0] END_MARKER_UNIT  = 16'h0000;

   // Results caused by one request: a run of replacement units, followed by
   // up to two other units (a scalar, a surrogate pair, or the end marker).
   typedef struct packed {
      logic [2:0]           reps;   // replacement units first, 0 to 4
      logic [1:0]           tails;  // further units after them, 0 to 2
      logic [UnitWidth-1:0] tail0;
      logic [UnitWidth-1:0] tail1;
      logic                 eot;    // the final unit is the end marker
   } utt_group_type;

endpackage

// File: rtl/core/utt_decode.sv
// ----------------------------------------------------------------------------
// utt_decode: UTF-8 sequence decoder stage
// Registers the incoming byte, tracks the pending multi-byte sequence and
// forms the group of code units that the byte causes, in one pass.
// ----------------------------------------------------------------------------
module utt_decode (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [utt_pkg::ByteWidth-1:0]  req_tdata,
   output logic                           grp_valid,
   input  logic                           grp_ready,
   output utt_pkg::utt_group_type         grp
);
   import utt_pkg::*;

   logic [ByteWidth-1:0] byte_ff;
   logic [ByteWidth-1:0] byte_in;
   logic                 byte_valid_ff;
   logic                 byte_valid_in;

   logic [CpWidth-1:0]   cp_ff;
   logic [CpWidth-1:0]   cp_in;
   logic [2:0]           len_ff;
   logic [2:0]           len_in;
   logic [2:0]           taken_ff;
   logic [2:0]           taken_in;

   logic                 pending;
   logic                 is_cont;
   logic [CpWidth-1:0]   cp_cat;
   logic [2:0]           taken_inc;
   logic                 finish;
   logic                 overlong;
   logic                 bad;
   logic [19:0]          supp;
   logic                 advance;
   logic [2:0]           total;
   utt_group_type        group;

   // Sequence bookkeeping for a continuation byte.
   assign pending   = (len_ff != 3'd0);
   assign is_cont   = (byte_ff[7:6] == 2'b10);
   assign cp_cat    = {cp_ff[CpWidth-7:0], byte_ff[5:0]};
   assign taken_inc = taken_ff + 3'd1;
   assign finish    = (taken_inc >= len_ff);
   assign supp      = 20'(cp_cat - 21'h010000);

   // A finished sequence is rejected when overlong, a surrogate or out of range.
   always_comb begin
      overlong = ((len_ff == 3'd2) && (cp_cat < 21'h000080)) ||
                 ((len_ff == 3'd3) && (cp_cat < 21'h000800)) ||
                 ((len_ff == 3'd4) && (cp_cat < 21'h010000));
      bad = overlong || (cp_cat > 21'h10FFFF) ||
            (cp_cat inside {[21'h00D800:21'h00DFFF]});
   end

   // Result group and next sequence state for the registered byte.
   always_comb begin
      group       = '0;
      cp_in       = cp_ff;
      len_in      = len_ff;
      taken_in    = taken_ff;
      if (byte_ff == 8'h00) begin
         // Terminator: flush pending bytes, then the end marker.
         group.reps  = pending ? taken_ff : 3'd0;
         group.tails = 2'd1;
         group.tail0 = END_MARKER_UNIT;
         group.eot   = 1'b1;
         cp_in       = '0;
         len_in      = 3'd0;
         taken_in    = 3'd0;
      end else if (pending && is_cont) begin
         if (finish) begin
            cp_in    = '0;
            len_in   = 3'd0;
            taken_in = 3'd0;
            if (bad) begin
               group.reps = len_ff;
            end else if (cp_cat <= 21'h00FFFF) begin
               group.tails = 2'd1;
               group.tail0 = cp_cat[UnitWidth-1:0];
            end else begin
               group.tails = 2'd2;
               group.tail0 = 16'hD800 + {6'd0, supp[19:10]};
               group.tail1 = 16'hDC00 + {6'd0, supp[9:0]};
            end
         end else begin
            cp_in    = cp_cat;
            taken_in = taken_inc;
         end
      end else begin
         // A broken sequence yields one replacement per byte taken; the byte
         // is then decoded as a fresh lead.
         group.reps = pending ? taken_ff : 3'd0;
         cp_in      = '0;
         len_in     = 3'd0;
         taken_in   = 3'd0;
         if (byte_ff[7] == 1'b0) begin
            group.tails = 2'd1;
            group.tail0 = {8'd0, byte_ff};
         end else if (byte_ff[7:5] == 3'b110) begin
            cp_in    = {16'd0, byte_ff[4:0]};
            len_in   = 3'd2;
            taken_in = 3'd1;
         end else if (byte_ff[7:4] == 4'b1110) begin
            cp_in    = {17'd0, byte_ff[3:0]};
            len_in   = 3'd3;
            taken_in = 3'd1;
         end else if (byte_ff[7:3] == 5'b11110) begin
            cp_in    = {18'd0, byte_ff[2:0]};
            len_in   = 3'd4;
            taken_in = 3'd1;
         end else begin
            group.tails = 2'd1;
            group.tail0 = REPLACEMENT_UNIT;
         end
      end
   end

   // Handshake: the byte register moves on when the serializer takes the group.
   assign total      = group.reps + {1'b0, group.tails};
   assign grp        = group;
   assign grp_valid  = byte_valid_ff && (total != 3'd0);
   assign advance    = byte_valid_ff && grp_ready;
   assign req_tready = !byte_valid_ff || advance;

   always_comb begin
      byte_in       = byte_ff;
      byte_valid_in = byte_valid_ff;
      if (req_tvalid && req_tready) begin
         byte_in       = req_tdata;
         byte_valid_in = 1'b1;
      end else if (advance) begin
         byte_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (reset) begin
         byte_valid_ff <= 1'b0;
         cp_ff         <= '0;
         len_ff        <= 3'd0;
         taken_ff      <= 3'd0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         if (advance) begin
            cp_ff    <= cp_in;
            len_ff   <= len_in;
            taken_ff <= taken_in;
         end
      end
   end

`ifndef SYNTHESIS
   // A pending sequence always has a legal length and a partial byte count.
   assert property (@(posedge clock) disable iff (reset)
      (len_ff == 3'd0) || (len_ff == 3'd2) || (len_ff == 3'd3) || (len_ff == 3'd4))
      else $error("utt_decode: illegal sequence length");

   assert property (@(posedge clock) disable iff (reset)
      pending |-> ((taken_ff != 3'd0) && (taken_ff < len_ff)))
      else $error("utt_decode: byte count out of range for pending sequence");

   // A held byte stays put until the serializer takes its group.
   assert property (@(posedge clock) disable iff (reset)
      (byte_valid_ff && !advance) |=> (byte_valid_ff && $stable(byte_ff)))
      else $error("utt_decode: byte lost while stalled");
`endif

endmodule

// File: rtl/core/utt_serialize.sv
// ----------------------------------------------------------------------------
// utt_serialize: result group register and unit serializer
// Holds one group of code units and hands them out one per cycle while rsp_tready
// is high, marking the final unit of the group and the end marker.
// ----------------------------------------------------------------------------
module utt_serialize (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           grp_valid,
   output logic                           grp_ready,
   input  utt_pkg::utt_group_type         grp,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [utt_pkg::UnitWidth-1:0]  rsp_tdata,
   output logic                           rsp_tlast,
   output logic                           rsp_tuser
);
   import utt_pkg::*;

   utt_group_type grp_ff;
   utt_group_type grp_in;
   logic          grp_valid_ff;
   logic          grp_valid_in;
   logic [1:0]    idx_ff;
   logic [1:0]    idx_in;

   logic [2:0]    total;
   logic [2:0]    idx_ext;
   logic [2:0]    tail_pos;
   logic          last;
   logic          take;

   // Select the unit at the current position of the group.
   assign total    = grp_ff.reps + {1'b0, grp_ff.tails};
   assign idx_ext  = {1'b0, idx_ff};
   assign tail_pos = idx_ext - grp_ff.reps;
   assign last     = (idx_ext == (total - 3'd1));

   always_comb begin
      if (idx_ext < grp_ff.reps) begin
         rsp_tdata = REPLACEMENT_UNIT;
      end else if (tail_pos == 3'd0) begin
         rsp_tdata = grp_ff.tail0;
      end else begin
         rsp_tdata = grp_ff.tail1;
      end
   end

   assign rsp_tvalid = grp_valid_ff;
   assign rsp_tlast  = last;
   assign rsp_tuser  = grp_ff.eot && last;

   // The register frees up in the same cycle its final unit is taken.
   assign take      = rsp_tvalid && rsp_tready;
   assign grp_ready = !grp_valid_ff || (take && last);

   always_comb begin
      grp_in       = grp_ff;
      grp_valid_in = grp_valid_ff;
      idx_in       = idx_ff;
      if (grp_valid && grp_ready) begin
         grp_in       = grp;
         grp_valid_in = 1'b1;
         idx_in       = 2'd0;
      end else if (take && last) begin
         grp_valid_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
      if (reset) begin
         grp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         grp_valid_ff <= grp_valid_in;
         idx_ff       <= idx_in;
      end
   end

`ifndef SYNTHESIS
   // A held group is never empty and the position stays inside it.
   assert property (@(posedge clock) disable iff (reset)
      grp_valid_ff |-> ((total != 3'd0) && (total <= 3'd4) && (idx_ext < total)))
      else $error("utt_serialize: position outside the held group");

   // The end marker is always the final unit of its request.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && (rsp_tdata == END_MARKER_UNIT)))
      else $error("utt_serialize: end marker not final or not zero");

   // A unit taken that is not the final one advances the position by one.
   assert property (@(posedge clock) disable iff (reset)
      (take && !last) |=> (grp_valid_ff && (idx_ff == ($past(idx_ff) + 2'd1))))
      else $error("utt_serialize: position did not advance");
`endif

endmodule

// File: rtl/core/utf8_to_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder: UTF-8 byte stream to UTF-16 code unit stream
// Decodes up to one byte per cycle; invalid bytes become U+FFFD, code points
// above U+FFFF become surrogate pairs, and a zero byte flushes and ends text.
//
//   Channel  Direction  tdata                 tlast           tuser
//   req_     in         in_byte [7:0]         -               -
//   rsp_     out        utf16_unit [15:0]     last_of_run     end_of_text
//
// A request is registered, decoded in the next cycle into a group of 0 to 4
// code units; the group register hands out one unit per cycle unless stalled.
// Throughput is one request per cycle while each request yields at most one
// unit and rsp_tready stays high; a request that yields more units holds the
// input until the single output port of the group register has sent them all.
// Reset clears the pending sequence and both stage valid flags.
// A stalled rsp_tready backs up into req_tready with no loss.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [utt_pkg::ByteWidth-1:0]  req_tdata,   // [7:0] in_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [utt_pkg::UnitWidth-1:0]  rsp_tdata,   // [15:0] utf16_unit
   output logic                           rsp_tlast,   // last_of_run
   output logic                           rsp_tuser    // [0] end_of_text
);
   import utt_pkg::*;

   utt_group_type grp;
   logic          grp_valid;
   logic          grp_ready;

   // Byte register, sequence state and group forming.
   utt_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .grp_valid  (grp_valid),
      .grp_ready  (grp_ready),
      .grp        (grp)
   );

   // Group register and per-unit output.
   utt_serialize u_serialize (
      .clock      (clock),
      .reset      (reset),
      .grp_valid  (grp_valid),
      .grp_ready  (grp_ready),
      .grp        (grp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the UTF-8 to UTF-16 transcoder
// Sends a short table of directed bytes and then a stream of random text,
// mostly well-formed multi-byte sequences with broken, truncated, overlong
// and out-of-range ones mixed in. A transcoding model or a typed table row
// predicts the code units of each accepted request, and every unit that leaves
// the block is compared in order. The sender pauses in bursts and the receiver
// throttles on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
   import utt_pkg::*;

   localparam logic [7:0]  TERMINATOR     = 8'h00;
   localparam logic [20:0] SUPP_BASE      = 21'h010000;
   localparam logic [20:0] MAX_CP         = 21'h10FFFF;
   localparam logic [20:0] SURR_FIRST     = 21'h00D800;
   localparam logic [20:0] SURR_LAST      = 21'h00DFFF;
   localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
   localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;
   localparam int          RANDOM_TOTAL   = 330;
   localparam int          IDLE_LIMIT     = 1000;

   typedef struct packed {
      logic [15:0] unit;
      logic        last;
      logic        eot;
   } unit_rec_type;

   typedef struct packed {
      logic [7:0]   in_byte;
      logic         typed;
      unit_rec_type exp;
   } stim_row_type;

   typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_THROTTLED} rx_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   stim_row_type stim_q[$];
   unit_rec_type expected_units[$];
   unit_rec_type step_units[$];
   int           accepted_reqs = 0;
   int           mismatches    = 0;
   int           idle_cycles   = 0;

   // Transcoder state as the model keeps it.
   logic [20:0] cp_acc    = '0;
   logic [2:0]  seq_len   = '0;
   logic [2:0]  seq_taken = '0;

   rx_mode_type rx_mode    = RX_OPEN;
   int          phase_left = 0;

   always #6 clock = ~clock;

   utf8_to_utf16_transcoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // ------------------------------------------------------------------
   // Transcoding model
   // ------------------------------------------------------------------
   function automatic void put_unit(input logic [15:0] u, input logic eot);
      unit_rec_type r;
      r.unit = u;
      r.last = 1'b0;
      r.eot  = eot;
      step_units.insert(step_units.size(), r);
   endfunction

   function automatic void put_replacements(input logic [2:0] n);
      for (int i = 0; i < n && i < 4; i++) put_unit(REPLACEMENT_UNIT, 1'b0);
   endfunction

   function automatic void clear_sequence();
      cp_acc    = '0;
      seq_len   = '0;
      seq_taken = '0;
   endfunction

   function automatic void decode_lead(input logic [7:0] b);
      case (b) inside
         8'b0???????: put_unit({8'h00, b}, 1'b0);
         8'b110?????: begin
            cp_acc = {16'b0, b[4:0]};
            seq_len = 3'd2;
            seq_taken = 3'd1;
         end
         8'b1110????: begin
            cp_acc = {17'b0, b[3:0]};
            seq_len = 3'd3;
            seq_taken = 3'd1;
         end
         8'b11110???: begin
            cp_acc = {18'b0, b[2:0]};
            seq_len = 3'd4;
            seq_taken = 3'd1;
         end
         default: put_unit(REPLACEMENT_UNIT, 1'b0);
      endcase
   endfunction

   // Validates the gathered code point and emits it, split if needed.
   function automatic void finish_code_point();
      logic [20:0] cp;
      logic [20:0] v;
      logic        overlong;
      cp = cp_acc;
      v  = cp - SUPP_BASE;
      overlong = (seq_len == 3'd2 && cp < 21'h80) ||
                 (seq_len == 3'd3 && cp < 21'h800) ||
                 (seq_len == 3'd4 && cp < SUPP_BASE);
      if (overlong || cp > MAX_CP || (cp >= SURR_FIRST && cp <= SURR_LAST)) begin
         put_replacements(seq_len);
      end else if (cp < SUPP_BASE) begin
         put_unit(cp[15:0], 1'b0);
      end else begin
         put_unit(SURR_HIGH_BASE + {6'b0, v[19:10]}, 1'b0);
         put_unit(SURR_LOW_BASE + {6'b0, v[9:0]}, 1'b0);
      end
      clear_sequence();
   endfunction

   // Leaves the code units caused by one byte in step_units.
   function automatic void transcode_byte(input logic [7:0] b);
      step_units.delete();
      if (b == TERMINATOR) begin
         if (seq_len != 0) put_replacements(seq_taken);
         clear_sequence();
         put_unit(END_MARKER_UNIT, 1'b1);
      end else if (seq_len != 0) begin
         if (b[7:6] == 2'b10) begin
            cp_acc = {cp_acc[14:0], b[5:0]};
            seq_taken = seq_taken + 3'd1;
            if (seq_taken >= seq_len) finish_code_point();
         end else begin
            put_replacements(seq_taken);
            clear_sequence();
            decode_lead(b);
         end
      end else begin
         decode_lead(b);
      end
      if (step_units.size() > 0) begin
         step_units[step_units.size() - 1].last = 1'b1;
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------
   function automatic void table_row(input logic [7:0] b, input logic typed,
                                     input logic [15:0] u, input logic eot);
      stim_row_type row;
      row.in_byte  = b;
      row.typed    = typed;
      row.exp.unit = u;
      row.exp.last = 1'b1;
      row.exp.eot  = eot;
      stim_q.insert(stim_q.size(), row);
   endfunction

   function automatic void add_byte(input logic [7:0] b);
      table_row(b, 1'b0, 16'h0000, 1'b0);
   endfunction

   // Encodes cp in len bytes and keeps the first keep of them.
   function automatic void add_code_point(input logic [20:0] cp, input int len,
                                          input int keep);
      logic [7:0] seq [4];
      case (len)
         1: seq[0] = cp[7:0];
         2: begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
         end
         3: begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
         end
         default: begin
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int i = 0; i < keep; i++) add_byte(seq[i]);
   endfunction

   function automatic void build_random_text();
      int pick;
      int len;
      while (stim_q.size() < RANDOM_TOTAL) begin
         pick = $urandom_range(0, 99);
         if (pick < 22) begin
            add_code_point(21'($urandom_range(1, 'h7F)), 1, 1);
         end else if (pick < 40) begin
            add_code_point(21'($urandom_range('h80, 'h7FF)), 2, 2);
         end else if (pick < 58) begin
            add_code_point(21'($urandom_range('h800, 'hFFFF)), 3, 3);
         end else if (pick < 74) begin
            add_code_point(21'($urandom_range('h10000, 'h10FFFF)), 4, 4);
         end else if (pick < 79) begin
            add_byte(TERMINATOR);
         end else if (pick < 87) begin
            add_byte(8'($urandom_range(1, 255)));
         end else if (pick < 93) begin
            // Truncated sequence; whatever follows breaks it.
            len = $urandom_range(2, 4);
            add_code_point(21'($urandom_range('h10000, 'h10FFFF) >> (5 * (4 - len))),
                           len, $urandom_range(1, len - 1));
         end else if (pick < 96) begin
            // Overlong form of a code point that fits in fewer bytes.
            len = $urandom_range(2, 4);
            add_code_point(21'($urandom_range(0, (len == 2) ? 'h7F :
                                                 ((len == 3) ? 'h7FF : 'hFFFF))),
                           len, len);
         end else if (pick < 98) begin
            add_code_point(21'($urandom_range('hD800, 'hDFFF)), 3, 3);
         end else begin
            add_code_point(21'($urandom_range('h110000, 'h1FFFFF)), 4, 4);
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Receiver throttling: open, coin-flip, or one cycle in four.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (phase_left == 0) begin
         rx_mode    <= rx_mode_type'($urandom_range(0, 2));
         phase_left <= $urandom_range(8, 64);
      end else begin
         phase_left <= phase_left - 1;
      end
      case (rx_mode)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
         default:   rsp_tready <= (phase_left[1:0] == 2'b00);
      endcase
   end

   // ------------------------------------------------------------------
   // Prediction on each accepted request, checking on each result.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      unit_rec_type got;
      unit_rec_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            transcode_byte(req_tdata);
            if (stim_q[accepted_reqs].typed) begin
               expected_units.insert(expected_units.size(), stim_q[accepted_reqs].exp);
            end else begin
               foreach (step_units[i]) begin
                  expected_units.insert(expected_units.size(), step_units[i]);
               end
            end
            accepted_reqs = accepted_reqs + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.unit = rsp_tdata;
            got.last = rsp_tlast;
            got.eot  = rsp_tuser;
            if (expected_units.size() == 0) begin
               $display("%0t: unexpected result unit=%h last=%b eot=%b",
                        $time, got.unit, got.last, got.eot);
               mismatches = mismatches + 1;
            end else begin
               want = expected_units.pop_front();
               if (got.unit !== want.unit) begin
                  $display("%0t: utf16_unit expected %h actual %h",
                           $time, want.unit, got.unit);
                  mismatches = mismatches + 1;
               end
               if (got.last !== want.last) begin
                  $display("%0t: last_of_run expected %b actual %b",
                           $time, want.last, got.last);
                  mismatches = mismatches + 1;
               end
               if (got.eot !== want.eot) begin
                  $display("%0t: end_of_text expected %b actual %b",
                           $time, want.eot, got.eot);
                  mismatches = mismatches + 1;
               end
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either side.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender: directed table, then random text, in bursts.
   // ------------------------------------------------------------------
   initial begin
      int send_idx;
      int burst;
      int gap;

      //         byte   typed  unit                eot
      table_row(8'h00, 1'b1, END_MARKER_UNIT,     1'b1);  // end marker from reset
      table_row(8'h7F, 1'b1, 16'h007F,            1'b0);  // largest ASCII
      table_row(8'hFF, 1'b1, REPLACEMENT_UNIT,    1'b0);  // bad lead
      table_row(8'h80, 1'b1, REPLACEMENT_UNIT,    1'b0);  // stray continuation
      table_row(8'hC0, 1'b0, 16'h0000,            1'b0);  // overlong two-byte
      table_row(8'h80, 1'b0, 16'h0000,            1'b0);
      table_row(8'hE0, 1'b0, 16'h0000,            1'b0);  // broken by ASCII
      table_row(8'h80, 1'b0, 16'h0000,            1'b0);
      table_row(8'h41, 1'b0, 16'h0000,            1'b0);
      table_row(8'hED, 1'b0, 16'h0000,            1'b0);  // encoded surrogate
      table_row(8'hA0, 1'b0, 16'h0000,            1'b0);
      table_row(8'h80, 1'b0, 16'h0000,            1'b0);
      table_row(8'hF0, 1'b0, 16'h0000,            1'b0);  // surrogate pair
      table_row(8'h9F, 1'b0, 16'h0000,            1'b0);
      table_row(8'h98, 1'b0, 16'h0000,            1'b0);
      table_row(8'h80, 1'b0, 16'h0000,            1'b0);
      table_row(8'hF7, 1'b0, 16'h0000,            1'b0);  // lead beyond U+10FFFF
      table_row(8'hBF, 1'b0, 16'h0000,            1'b0);
      table_row(8'hBF, 1'b0, 16'h0000,            1'b0);
      table_row(8'hBF, 1'b0, 16'h0000,            1'b0);
      table_row(8'hF4, 1'b0, 16'h0000,            1'b0);  // truncated by terminator
      table_row(8'h8F, 1'b0, 16'h0000,            1'b0);
      table_row(8'hBF, 1'b0, 16'h0000,            1'b0);
      table_row(8'h00, 1'b0, 16'h0000,            1'b0);
      build_random_text();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idx = 0;
      while (send_idx < stim_q.size()) begin
         burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                             : $urandom_range(1, 8);
         for (int k = 0; k < burst && send_idx < stim_q.size(); k++) begin
            req_tvalid <= 1'b1;
            req_tdata  <= stim_q[send_idx].in_byte;
            do @(posedge clock); while (!req_tready);
            send_idx = send_idx + 1;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0 || send_idx == stim_q.size()) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      // Drain, then keep watching for stray results.
      while (expected_units.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatches == 0 && expected_units.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/utt_pkg.sv
rtl/core/utt_decode.sv
rtl/core/utt_serialize.sv
rtl/core/utf8_to_utf16_transcoder.sv
tb/sv/tb_top.sv
